### hdl/selective_repeat_receiver_defines.svh
// assertion macros for the selective repeat receiver
// used by the top level only, no other dependencies
`ifndef SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH

// condition implies consequence in the same cycle
`define SRR_ASSERT_SAME(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("srr assertion failed");

// condition implies consequence in the next cycle
`define SRR_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("srr assertion failed");

`endif

### hdl/srr_pkg.sv
// shared types and constants for the selective repeat receiver
// no dependencies
`default_nettype none

package srr_pkg;

  // default configuration
  localparam int unsigned SEQ_SPACE_DEF    = 8;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  // result kinds
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_DELIVER
  } srr_state_e;

  // per cell control from the controller
  typedef struct packed {
    logic wr;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hdl/srr_if.sv
// valid/ready channel interfaces for packets in and results out
// no dependencies
`default_nettype none

interface srr_in_if #(
  parameter int unsigned SEQ_W  = 3,
  parameter int unsigned DATA_W = 32
);
  logic              valid;
  logic              ready;
  logic [SEQ_W-1:0]  seq_num;
  logic              checksum_ok;
  logic [DATA_W-1:0] payload_word;

  modport source (output valid, seq_num, checksum_ok, payload_word, input ready);
  modport sink   (input valid, seq_num, checksum_ok, payload_word, output ready);
endinterface

interface srr_out_if #(
  parameter int unsigned SEQ_W  = 3,
  parameter int unsigned DATA_W = 32
);
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SEQ_W-1:0]  ack_num;
  logic [DATA_W-1:0] data_word;
  logic              last;

  modport source (output valid, kind, ack_num, data_word, last, input ready);
  modport sink   (input valid, kind, ack_num, data_word, last, output ready);
endinterface

`default_nettype wire

### hdl/selective_repeat_receiver.sv
// selective repeat arq receiver top level: controller, output register, slot chain
// depends on srr_pkg, srr_if, srr_cell and selective_repeat_receiver_defines.svh
//
//  channel | dir | transaction
//  in_i    | in  | one packet: seq_num, checksum_ok, payload_word
//  out_o   | out | one result: kind, ack_num, data_word, last
//
// a packet is acked, then releases its in-order run of up to SEQ_SPACE/2 buffered words,
// the slot chain shifting one slot into the output register per cycle unless the output stalls
// a corrupted packet is accepted and leaves no result
// reset clears the controller state, window base, slot valid flags and output valid flag at once
// a stalled output holds its result; packets wait until the release run has drained
`default_nettype none

`include "selective_repeat_receiver_defines.svh"

module selective_repeat_receiver #(
  parameter int unsigned SEQ_SPACE    = srr_pkg::SEQ_SPACE_DEF,
  parameter int unsigned PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  srr_in_if.sink    in_i,
  srr_out_if.source out_o
);
  import srr_pkg::*;

  localparam int unsigned WINDOW = SEQ_SPACE / 2;
  localparam int unsigned SEQ_W  = $clog2(SEQ_SPACE);
  localparam logic [SEQ_W:0]   SPACE_X = (SEQ_W+1)'(SEQ_SPACE);
  localparam logic [SEQ_W-1:0] SEQ_MAX = SEQ_W'(SEQ_SPACE - 1);
  localparam logic [SEQ_W-1:0] WIN_N   = SEQ_W'(WINDOW);

  srr_state_e state_q, state_d;
  logic [SEQ_W-1:0] base_q, base_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_load;
  logic                    kind_q, kind_d;
  logic [SEQ_W-1:0]        ack_q, ack_d;
  logic [PAYLOAD_BITS-1:0] data_q, data_d;
  logic                    last_q, last_d;

  logic                    emit_ok;
  logic                    in_acc;
  logic [SEQ_W:0]          seq_x;
  logic [SEQ_W-1:0]        seq_red;
  logic [SEQ_W:0]          off_sum;
  logic [SEQ_W-1:0]        off;
  logic                    in_win;
  logic                    head_ready;
  logic                    do_write;
  logic                    do_shift;

  cell_ctrl_t              ctrl      [WINDOW];
  logic [WINDOW-1:0]       cell_valid;
  logic [PAYLOAD_BITS-1:0] cell_data [WINDOW];

  // handshakes
  assign emit_ok    = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && emit_ok;
  assign in_acc     = in_i.valid && in_i.ready;

  // sequence number reduction and offset from the window base
  always_comb begin
    seq_x   = {1'b0, SEQ_W'(in_i.seq_num)};
    seq_red = (seq_x >= SPACE_X) ? SEQ_W'(seq_x - SPACE_X) : SEQ_W'(seq_x);
    off_sum = {1'b0, seq_red} + SPACE_X - {1'b0, base_q};
    off     = (off_sum >= SPACE_X) ? SEQ_W'(off_sum - SPACE_X) : SEQ_W'(off_sum);
  end

  assign in_win     = off < WIN_N;
  assign head_ready = in_win && ((off == '0) || cell_valid[0]);

  // controller: ack on accept, then drain the head run
  always_comb begin
    state_d  = state_q;
    base_d   = base_q;
    out_load = 1'b0;
    kind_d   = kind_q;
    ack_d    = ack_q;
    data_d   = data_q;
    last_d   = last_q;
    do_write = 1'b0;
    do_shift = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.checksum_ok) begin
          out_load = 1'b1;
          kind_d   = KIND_ACK;
          ack_d    = seq_red;
          data_d   = '0;
          last_d   = !head_ready;
          do_write = in_win;
          if (head_ready) begin
            state_d = ST_DELIVER;
          end
        end
      end
      ST_DELIVER: begin
        if (emit_ok) begin
          out_load = 1'b1;
          kind_d   = KIND_DATA;
          ack_d    = '0;
          data_d   = cell_data[0];
          last_d   = !cell_valid[1];
          do_shift = 1'b1;
          base_d   = (base_q == SEQ_MAX) ? '0 : base_q + SEQ_W'(1);
          if (!cell_valid[1]) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid follows loads and takes
  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q <= kind_d;
      ack_q  <= ack_d;
      data_q <= data_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = kind_q;
  assign out_o.ack_num   = ack_q;
  assign out_o.data_word = data_q;
  assign out_o.last      = last_q;

  // per cell control
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      ctrl[i].wr    = do_write && (off == SEQ_W'(i));
      ctrl[i].shift = do_shift;
    end
  end

  // slot chain, each cell hands its contents to the one below on a shift
  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    logic                    up_valid;
    logic [PAYLOAD_BITS-1:0] up_data;
    if (g == WINDOW - 1) begin : g_top
      assign up_valid = 1'b0;
      assign up_data  = '0;
    end else begin : g_mid
      assign up_valid = cell_valid[g+1];
      assign up_data  = cell_data[g+1];
    end
    srr_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[g]),
      .wr_data_i  (PAYLOAD_BITS'(in_i.payload_word)),
      .up_valid_i (up_valid),
      .up_data_i  (up_data),
      .valid_o    (cell_valid[g]),
      .data_o     (cell_data[g])
    );
  end

  // assertions
  `SRR_ASSERT_SAME(a_deliver_head, clk_i, rst_ni, state_q == ST_DELIVER, cell_valid[0])
  `SRR_ASSERT_SAME(a_ready_idle, clk_i, rst_ni, in_i.ready, state_q == ST_IDLE)
  `SRR_ASSERT_SAME(a_base_range, clk_i, rst_ni, 1'b1, base_q <= SEQ_MAX)
  `SRR_ASSERT_NEXT(a_run_end, clk_i, rst_ni, (state_q == ST_DELIVER) && emit_ok && !cell_valid[1], (state_q == ST_IDLE) && out_o.valid && out_o.last)

endmodule

`default_nettype wire

### hdl/srr_cell.sv
// one receive window slot: valid flag and buffered payload word
// depends on srr_pkg
`default_nettype none

module srr_cell #(
  parameter int unsigned PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire srr_pkg::cell_ctrl_t     ctrl_i,
  input  wire logic [PAYLOAD_BITS-1:0] wr_data_i,
  input  wire logic                    up_valid_i,
  input  wire logic [PAYLOAD_BITS-1:0] up_data_i,
  output logic                         valid_o,
  output logic [PAYLOAD_BITS-1:0]      data_o
);
  import srr_pkg::*;

  logic                    valid_q;
  logic [PAYLOAD_BITS-1:0] data_q;

  // valid flag: set on write, takes the upper neighbor on shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.wr) begin
      valid_q <= 1'b1;
    end else if (ctrl_i.shift) begin
      valid_q <= up_valid_i;
    end
  end

  // payload word, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      data_q <= wr_data_i;
    end else if (ctrl_i.shift) begin
      data_q <= up_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire
